@@ hdl/adc_tw_pkg.sv @@
// shared constants and types for the two-wire serial adc master
// no dependencies
`default_nettype none
package adc_tw_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int EXTRA_CLOCKS = 3;
  localparam int TAIL_PULSES  = 19;
  localparam int SAMPLE_W     = 24;
  localparam int CNT_W        = 6;
  localparam int HALF_W       = 16;
  localparam int CFG_W        = 8;
  localparam int REQ_W        = 2;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd8;

  localparam logic [CFG_W-1:0] CMD_WRITE = 8'h65;
  localparam logic [CFG_W-1:0] CMD_READ  = 8'h56;

  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  localparam logic [CNT_W-1:0] PC_READOUT_END = CNT_W'(SAMPLE_BITS + EXTRA_CLOCKS);
  localparam logic [CNT_W-1:0] PC_SAMPLE_LAST = CNT_W'(SAMPLE_BITS);
  localparam logic [CNT_W-1:0] PC_FRAME_END   = CNT_W'(SAMPLE_BITS + EXTRA_CLOCKS
                                                       + TAIL_PULSES);
  localparam logic [CNT_W-1:0] PC_CFG_FIRST   = CNT_W'(SAMPLE_BITS + EXTRA_CLOCKS + 11);
  localparam logic [CNT_W-1:0] PC_CFG_LAST    = CNT_W'(SAMPLE_BITS + EXTRA_CLOCKS + 18);

  typedef struct packed {
    logic                sclk_level;
    logic                dout_drive_enable;
    logic                dout_drive_value;
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample_value;
    logic                config_valid;
    logic [CFG_W-1:0]    config_value;
    logic                busy_res;
  } res_t;

endpackage
`default_nettype wire

@@ hdl/adc_tw_step.sv @@
// per-tick sequencer of the serial master: state registers and next-state logic
// depends on adc_tw_pkg
`default_nettype none
module adc_tw_step (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [adc_tw_pkg::HALF_W-1:0]   cfg_wdata_i,
  input  wire logic                            step_en_i,
  input  wire logic [adc_tw_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [adc_tw_pkg::CFG_W-1:0]    config_byte_i,
  input  wire logic                            dout_level_i,
  output adc_tw_pkg::res_t                     res_o
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_WAIT  = 4'd1;
  localparam logic [3:0] PH_CLOCK = 4'd2;

  logic [3:0]                         phase_q, phase_d;
  logic [adc_tw_pkg::REQ_W-1:0]       op_q, op_d;
  logic [adc_tw_pkg::CNT_W-1:0]       pc_q, pc_d;
  logic [adc_tw_pkg::HALF_W-1:0]      ht_q, ht_d;
  logic                               ch_q, ch_d;
  logic                               prev_q;
  logic [adc_tw_pkg::SAMPLE_BITS-1:0] sin_q, sin_d;
  logic [adc_tw_pkg::CFG_W-1:0]       sout_q, sout_d;
  logic [adc_tw_pkg::CFG_W-1:0]       cin_q, cin_d;
  logic [adc_tw_pkg::HALF_W-1:0]      half_q;

  logic [adc_tw_pkg::HALF_W-1:0]      half_eff;
  logic [adc_tw_pkg::HALF_W:0]        ht_inc;
  logic [adc_tw_pkg::CFG_W-1:0]       cmd;
  logic [adc_tw_pkg::CNT_W-1:0]       q;
  logic [2:0]                         cmd_idx;
  logic [2:0]                         so_idx;
  logic                               drv_en, drv_val;
  logic [adc_tw_pkg::CNT_W-1:0]       last_pc;

  assign half_eff = (half_q == '0) ? adc_tw_pkg::HALF_W'(1) : half_q;
  assign ht_inc   = {1'b0, ht_q} + (adc_tw_pkg::HALF_W + 1)'(1);
  assign last_pc  = (op_q == adc_tw_pkg::REQ_SAMPLE) ? adc_tw_pkg::PC_READOUT_END
                                                     : adc_tw_pkg::PC_FRAME_END;

  // data line drive during the command and config tail
  always_comb begin
    cmd     = (op_q == adc_tw_pkg::REQ_WRITE) ? adc_tw_pkg::CMD_WRITE : adc_tw_pkg::CMD_READ;
    q       = pc_q - adc_tw_pkg::PC_READOUT_END;
    cmd_idx = 3'(4'd9 - q[3:0]);
    so_idx  = 3'(5'd18 - q[4:0]);
    drv_en  = 1'b0;
    drv_val = 1'b0;
    if ((op_q >= adc_tw_pkg::REQ_WRITE) && (pc_q > adc_tw_pkg::PC_READOUT_END) &&
        !((op_q == adc_tw_pkg::REQ_READ) && (q > 6'd9)) && (q <= 6'd19)) begin
      drv_en = 1'b1;
      if (q <= 6'd2) begin
        drv_val = 1'b1;
      end else if (q <= 6'd9) begin
        drv_val = cmd[cmd_idx];
      end else if (q == 6'd10) begin
        drv_val = cmd[0];
      end else if (q <= 6'd18) begin
        drv_val = sout_q[so_idx];
      end else begin
        drv_val = sout_q[0];
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    pc_d    = pc_q;
    ht_d    = ht_q;
    ch_d    = ch_q;
    sin_d   = sin_q;
    sout_d  = sout_q;
    cin_d   = cin_q;
    res_o   = '0;
    res_o.busy_res = (phase_q != PH_IDLE);
    unique case (phase_q)
      PH_IDLE: begin
        if (req_type_i != adc_tw_pkg::REQ_NONE) begin
          op_d           = req_type_i;
          sout_d         = config_byte_i;
          sin_d          = '0;
          cin_d          = '0;
          phase_d        = PH_WAIT;
          res_o.busy_res = 1'b1;
        end
      end
      PH_WAIT: begin
        if (prev_q && !dout_level_i) begin
          phase_d = PH_CLOCK;
          pc_d    = adc_tw_pkg::CNT_W'(1);
          ch_d    = 1'b1;
          ht_d    = '0;
        end
      end
      PH_CLOCK: begin
        res_o.sclk_level        = ch_q;
        res_o.dout_drive_enable = drv_en;
        res_o.dout_drive_value  = drv_val;
        if (ht_inc >= {1'b0, half_eff}) begin
          ht_d = '0;
          if (ch_q) begin
            if (pc_q <= adc_tw_pkg::PC_SAMPLE_LAST) begin
              sin_d = {sin_q[adc_tw_pkg::SAMPLE_BITS-2:0], dout_level_i};
            end else if ((op_q == adc_tw_pkg::REQ_READ) &&
                         (pc_q >= adc_tw_pkg::PC_CFG_FIRST) &&
                         (pc_q <= adc_tw_pkg::PC_CFG_LAST)) begin
              cin_d = {cin_q[adc_tw_pkg::CFG_W-2:0], dout_level_i};
            end
            ch_d = 1'b0;
          end else begin
            if (pc_q == adc_tw_pkg::PC_READOUT_END) begin
              res_o.sample_valid = 1'b1;
              res_o.sample_value = adc_tw_pkg::SAMPLE_W'($signed(sin_q));
            end
            if (pc_q >= last_pc) begin
              if (op_q == adc_tw_pkg::REQ_READ) begin
                res_o.config_valid = 1'b1;
                res_o.config_value = cin_q;
              end
              phase_d = PH_IDLE;
              pc_d    = '0;
            end else begin
              pc_d = pc_q + adc_tw_pkg::CNT_W'(1);
              ch_d = 1'b1;
            end
          end
        end else begin
          ht_d = ht_inc[adc_tw_pkg::HALF_W-1:0];
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= '0;
      pc_q    <= '0;
      ht_q    <= '0;
      ch_q    <= 1'b0;
      prev_q  <= 1'b0;
      sin_q   <= '0;
      sout_q  <= '0;
      cin_q   <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      pc_q    <= pc_d;
      ht_q    <= ht_d;
      ch_q    <= ch_d;
      prev_q  <= dout_level_i;
      sin_q   <= sin_d;
      sout_q  <= sout_d;
      cin_q   <= cin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= adc_tw_pkg::HALF_RESET;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/adc_tw_obuf.sv @@
// result register with a skid stage so the input side keeps moving under stall
// depends on adc_tw_pkg
`default_nettype none
module adc_tw_obuf (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire adc_tw_pkg::res_t push_data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output adc_tw_pkg::res_t out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  adc_tw_pkg::res_t out_q, out_d;
  adc_tw_pkg::res_t skid_q, skid_d;
  logic             pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ hdl/adc_two_wire_serial_master_core.sv @@
// top level of the two-wire serial adc master: sequencer plus result buffer
// depends on adc_tw_pkg, adc_tw_step, adc_tw_obuf
//
// each input transaction is one tick of the serial interface: the sampled
// data/ready line level plus an optional request (sample read, config write,
// config read) that is only taken while the master is idle. every accepted
// tick produces exactly one result transaction with the sclk level, the data
// line drive, the sample and config pulses and the busy flag.
// an accepted result is registered in the result register, or in the
// one-entry skid stage while the receiver stalls; a transaction can be
// accepted every cycle while in_stall_o is low. a stalled receiver holds the
// result, and in_stall_o is raised only once the skid stage is occupied.
// cfg_we_i writes half_period_ticks (sclk half period in ticks, 0 acts as 1);
// write it only while the master is idle.
// reset clears the sequencer to idle, empties both result stages and sets
// half_period_ticks to 8.
`default_nettype none
module adc_two_wire_serial_master_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [adc_tw_pkg::HALF_W-1:0]       cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [adc_tw_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [adc_tw_pkg::CFG_W-1:0]        config_byte_i,
  input  wire logic                                dout_level_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     sclk_level_o,
  output logic                                     dout_drive_enable_o,
  output logic                                     dout_drive_value_o,
  output logic                                     sample_valid_o,
  output logic signed [adc_tw_pkg::SAMPLE_W-1:0]   sample_value_o,
  output logic                                     config_valid_o,
  output logic        [adc_tw_pkg::CFG_W-1:0]      config_value_o,
  output logic                                     busy_res_o
);

  logic             accept;
  logic             full;
  adc_tw_pkg::res_t step_res;
  adc_tw_pkg::res_t out_res;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = full;

  adc_tw_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .step_en_i     (accept),
    .req_type_i    (req_type_i),
    .config_byte_i (config_byte_i),
    .dout_level_i  (dout_level_i),
    .res_o         (step_res)
  );

  adc_tw_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign sclk_level_o        = out_res.sclk_level;
  assign dout_drive_enable_o = out_res.dout_drive_enable;
  assign dout_drive_value_o  = out_res.dout_drive_value;
  assign sample_valid_o      = out_res.sample_valid;
  assign sample_value_o      = $signed(out_res.sample_value);
  assign config_valid_o      = out_res.config_valid;
  assign config_value_o      = out_res.config_value;
  assign busy_res_o          = out_res.busy_res;

`ifndef SYNTH
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sample_valid_o || config_valid_o) |-> busy_res_o)
    else $error("completion pulse outside a busy transaction");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !sclk_level_o && !dout_drive_enable_o)
    else $error("serial lines active while idle");

  a_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> sample_value_o == '0)
    else $error("sample value nonzero without pulse");

  a_cfg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !config_valid_o |-> config_value_o == '0)
    else $error("config value nonzero without pulse");
`endif

endmodule
`default_nettype wire
